### hdl/csvft_pkg.sv
// Package for the CSV field tokenizer: character codes, line status codes,
// command codes and the command and result types shared by all modules.
// No dependencies.
package csvft_pkg;

    localparam int WS_HOLD_DEPTH_DEF = 16;
    localparam int MAX_FIELDS        = 64;
    localparam int COUNT_W           = 7;
    localparam int HOLD_N_W          = 9;
    localparam int CMDQ_DEPTH        = 4;
    localparam int OUTQ_DEPTH        = 4;

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_FIELDS < 127) ? MAX_FIELDS : 127);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] ST_EMPTY    = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_DATA_OK  = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_UNCLOSED = 3'd4;
    localparam logic [2:0] ST_WS_OVF   = 3'd5;

    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_EMIT  = 2'd1;
    localparam logic [1:0] CMD_COMMA = 2'd2;
    localparam logic [1:0] CMD_LINE  = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          data;
        logic [HOLD_N_W-1:0] n;
        logic [2:0]          status;
        logic [COUNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               field_end;
        logic               line_end;
        logic               last_of_run;
        logic [2:0]         line_status;
        logic [COUNT_W-1:0] column_count;
    } res_t;

endpackage

### hdl/csvft_front.sv
// Front part of the CSV field tokenizer: accepts items, tracks quoting,
// trimming and line state, and issues commands to the command queue.
// Depends on csvft_pkg.
module csvft_front
    import csvft_pkg::*;
#(
    parameter int WS_HOLD_DEPTH = WS_HOLD_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] char_byte,
    input  logic       is_line_end,
    output logic       full,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    localparam int CW = $clog2(WS_HOLD_DEPTH + 1);

    logic               quoted_reg, quoted_next;
    logic               qseen_reg, qseen_next;
    logic               fhc_reg, fhc_next;
    logic               lhc_reg, lhc_next;
    logic [CW-1:0]      held_reg, held_next;
    logic               ovf_reg, ovf_next;
    logic [COUNT_W-1:0] fields_reg, fields_next;
    logic               hdr_seen_reg, hdr_seen_next;
    logic [COUNT_W-1:0] hdr_w_reg, hdr_w_next;

    logic               accept;
    logic               unq;
    logic               do_cont;
    logic               ws;
    logic [COUNT_W-1:0] line_cnt;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c < COUNT_CAP) ? c + COUNT_W'(1) : COUNT_CAP;
        return r;
    endfunction

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign ws       = (char_byte == CH_SPACE) ||
                      ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
    assign line_cnt = sat_inc(fields_reg);

    always_comb
    begin
        quoted_next   = quoted_reg;
        qseen_next    = qseen_reg;
        fhc_next      = fhc_reg;
        lhc_next      = lhc_reg;
        held_next     = held_reg;
        ovf_next      = ovf_reg;
        fields_next   = fields_reg;
        hdr_seen_next = hdr_seen_reg;
        hdr_w_next    = hdr_w_reg;
        q_push        = 1'b0;
        q_cmd         = '0;
        unq           = 1'b0;
        do_cont       = 1'b0;

        if (accept)
        begin
            if (is_line_end)
            begin
                q_push       = 1'b1;
                q_cmd.kind   = CMD_LINE;
                q_cmd.count  = line_cnt;
                priority if (quoted_reg && !qseen_reg)
                begin
                    q_cmd.status = ST_UNCLOSED;
                end
                else if (ovf_reg)
                begin
                    q_cmd.status = ST_WS_OVF;
                end
                else if (!lhc_reg)
                begin
                    q_cmd.status = ST_EMPTY;
                end
                else if (!hdr_seen_reg)
                begin
                    q_cmd.status  = ST_HEADER;
                    hdr_seen_next = 1'b1;
                    hdr_w_next    = line_cnt;
                end
                else if (line_cnt != hdr_w_reg)
                begin
                    q_cmd.status = ST_MISMATCH;
                end
                else
                begin
                    q_cmd.status = ST_DATA_OK;
                end
                quoted_next = 1'b0;
                qseen_next  = 1'b0;
                fhc_next    = 1'b0;
                lhc_next    = 1'b0;
                held_next   = '0;
                ovf_next    = 1'b0;
                fields_next = '0;
            end
            else
            begin
                unq = 1'b1;
                if (quoted_reg)
                begin
                    unq = 1'b0;
                    if (qseen_reg)
                    begin
                        qseen_next = 1'b0;
                        if (char_byte == CH_QUOTE)
                        begin
                            do_cont = 1'b1;
                        end
                        else
                        begin
                            quoted_next = 1'b0;
                            unq         = 1'b1;
                        end
                    end
                    else if (char_byte == CH_QUOTE)
                    begin
                        qseen_next = 1'b1;
                    end
                    else
                    begin
                        do_cont = 1'b1;
                    end
                end

                if (unq)
                begin
                    priority if (char_byte == CH_COMMA)
                    begin
                        fields_next = line_cnt;
                        held_next   = '0;
                        fhc_next    = 1'b0;
                        q_push      = 1'b1;
                        q_cmd.kind  = CMD_COMMA;
                    end
                    else if (char_byte == CH_QUOTE && !fhc_reg)
                    begin
                        quoted_next = 1'b1;
                        qseen_next  = 1'b0;
                    end
                    else
                    begin
                        do_cont = 1'b1;
                    end
                end

                if (do_cont)
                begin
                    if (ws)
                    begin
                        if (fhc_reg)
                        begin
                            if (held_reg < CW'(WS_HOLD_DEPTH))
                            begin
                                q_push     = 1'b1;
                                q_cmd.kind = CMD_HOLD;
                                q_cmd.data = char_byte;
                                q_cmd.n    = HOLD_N_W'(held_reg);
                                held_next  = held_reg + CW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_EMIT;
                        q_cmd.data = char_byte;
                        q_cmd.n    = HOLD_N_W'(held_reg);
                        held_next  = '0;
                        fhc_next   = 1'b1;
                        lhc_next   = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg   <= 1'b0;
            qseen_reg    <= 1'b0;
            fhc_reg      <= 1'b0;
            lhc_reg      <= 1'b0;
            held_reg     <= '0;
            ovf_reg      <= 1'b0;
            fields_reg   <= '0;
            hdr_seen_reg <= 1'b0;
            hdr_w_reg    <= '0;
        end
        else
        begin
            quoted_reg   <= quoted_next;
            qseen_reg    <= qseen_next;
            fhc_reg      <= fhc_next;
            lhc_reg      <= lhc_next;
            held_reg     <= held_next;
            ovf_reg      <= ovf_next;
            fields_reg   <= fields_next;
            hdr_seen_reg <= hdr_seen_next;
            hdr_w_reg    <= hdr_w_next;
        end
    end

endmodule

### hdl/csvft_cmd_queue.sv
// Command queue between the front and back parts of the CSV field tokenizer.
// Small register-based first-in first-out store. Depends on csvft_pkg.
module csvft_cmd_queue
    import csvft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t rdata,
    output logic empty
);

    localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int NW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == NW'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = entry_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : rp_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hdl/csvft_back.sv
// Back part of the CSV field tokenizer: executes commands, keeps the held
// whitespace memory, drains it ahead of content and queues the results.
// Depends on csvft_pkg.
module csvft_back
    import csvft_pkg::*;
#(
    parameter int WS_HOLD_DEPTH = WS_HOLD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    output logic empty,
    input  logic pop,
    output res_t res
);

    localparam int CW  = $clog2(WS_HOLD_DEPTH + 1);
    localparam int AW  = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
    localparam int QAW = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int QCW = $clog2(OUTQ_DEPTH + 1);

    logic [7:0]     mem [WS_HOLD_DEPTH];
    logic [7:0]     mem_rd_reg;
    logic           mem_we, mem_re;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  n_cur;

    logic           s1_vld_reg;
    logic           s1_mem_reg;
    res_t           s1_res_reg;
    logic           issue, issue_mem;
    res_t           issue_res;

    res_t           oq_reg [OUTQ_DEPTH];
    logic [QAW-1:0] oq_wp_reg, oq_wp_next;
    logic [QAW-1:0] oq_rp_reg, oq_rp_next;
    logic [QCW-1:0] oq_cnt_reg, oq_cnt_next;
    logic           oq_push, oq_pop;
    logic           room;
    res_t           oq_in;

    assign n_cur = cmd.n[CW-1:0];
    assign room  = ((QCW + 1)'(oq_cnt_reg) + (QCW + 1)'(s1_vld_reg)) <
                   (QCW + 1)'(OUTQ_DEPTH);

    always_comb
    begin
        cmd_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        issue     = 1'b0;
        issue_mem = 1'b0;
        issue_res = '0;
        cnt_next  = cnt_reg;
        if (cmd_valid)
        begin
            unique case (cmd.kind)
                CMD_HOLD:
                begin
                    mem_we  = 1'b1;
                    cmd_pop = 1'b1;
                end
                CMD_EMIT:
                begin
                    if (room)
                    begin
                        issue                = 1'b1;
                        issue_res.byte_valid = 1'b1;
                        if (cnt_reg != n_cur)
                        begin
                            issue_mem = 1'b1;
                            mem_re    = 1'b1;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                        else
                        begin
                            issue_res.out_byte    = cmd.data;
                            issue_res.last_of_run = 1'b1;
                            cmd_pop               = 1'b1;
                            cnt_next              = '0;
                        end
                    end
                end
                CMD_COMMA:
                begin
                    if (room)
                    begin
                        issue                 = 1'b1;
                        issue_res.field_end   = 1'b1;
                        issue_res.last_of_run = 1'b1;
                        cmd_pop               = 1'b1;
                    end
                end
                CMD_LINE:
                begin
                    if (room)
                    begin
                        issue                  = 1'b1;
                        issue_res.field_end    = 1'b1;
                        issue_res.line_end     = 1'b1;
                        issue_res.last_of_run  = 1'b1;
                        issue_res.line_status  = cmd.status;
                        issue_res.column_count = cmd.count;
                        cmd_pop                = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd.n[AW-1:0]] <= cmd.data;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[cnt_reg[AW-1:0]];
        end
        s1_mem_reg <= issue_mem;
        s1_res_reg <= issue_res;
    end

    always_comb
    begin
        oq_in = s1_res_reg;
        if (s1_mem_reg)
        begin
            oq_in.out_byte = mem_rd_reg;
        end
    end

    assign oq_push = s1_vld_reg;
    assign empty   = (oq_cnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign res     = oq_reg[oq_rp_reg];

    always_comb
    begin
        oq_wp_next  = oq_wp_reg;
        oq_rp_next  = oq_rp_reg;
        oq_cnt_next = oq_cnt_reg;
        if (oq_push)
        begin
            oq_wp_next = (oq_wp_reg == QAW'(OUTQ_DEPTH - 1)) ? '0 : oq_wp_reg + QAW'(1);
        end
        if (oq_pop)
        begin
            oq_rp_next = (oq_rp_reg == QAW'(OUTQ_DEPTH - 1)) ? '0 : oq_rp_reg + QAW'(1);
        end
        if (oq_push && !oq_pop)
        begin
            oq_cnt_next = oq_cnt_reg + QCW'(1);
        end
        else if (oq_pop && !oq_push)
        begin
            oq_cnt_next = oq_cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wp_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            s1_vld_reg <= 1'b0;
            oq_wp_reg  <= '0;
            oq_rp_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            s1_vld_reg <= issue;
            oq_wp_reg  <= oq_wp_next;
            oq_rp_reg  <= oq_rp_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

### hdl/csv_field_tokenizer_unit.sv
// CSV field tokenizer top level: splits a byte stream into trimmed,
// optionally quoted fields and reports a status per line.
// Depends on csvft_pkg, csvft_front, csvft_cmd_queue and csvft_back.
//
// Usage:
//   Input side is a queue write port: drive char_byte / is_line_end and
//   raise push; the item is taken on a clock edge where full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on the result ports; raise pop to take it.
//   One item enters per cycle as long as the command queue has space.
//   A content byte that follows N held whitespace bytes yields N+1 results,
//   produced at one per cycle while the output queue has room; the held
//   bytes come from the held-whitespace memory read port.
//   Each result passes the command queue, stage register and output queue.
//   Quiet items (dropped or held whitespace, quote marks) yield no result.
//   When pop is held low, the output queue fills, the back part stops,
//   the command queue fills and full rises; nothing is dropped.
//   Reset clears all line and header state and both queues; the held
//   whitespace memory needs no clearing.
module csv_field_tokenizer_unit
    import csvft_pkg::*;
#(
    parameter int WS_HOLD_DEPTH = WS_HOLD_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         char_byte,
    input  logic               is_line_end,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               field_end,
    output logic               line_end,
    output logic               last_of_run,
    output logic [2:0]         line_status,
    output logic [COUNT_W-1:0] column_count
);

    logic q_full, q_empty, q_push, q_pop;
    cmd_t q_wcmd, q_rcmd;
    res_t res;

    csvft_front #(
        .WS_HOLD_DEPTH(WS_HOLD_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .char_byte   (char_byte),
        .is_line_end (is_line_end),
        .full        (full),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_wcmd)
    );

    csvft_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wcmd),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rcmd),
        .empty (q_empty)
    );

    csvft_back #(
        .WS_HOLD_DEPTH(WS_HOLD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_rcmd),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign out_byte     = res.out_byte;
    assign byte_valid   = res.byte_valid;
    assign field_end    = res.field_end;
    assign line_end     = res.line_end;
    assign last_of_run  = res.last_of_run;
    assign line_status  = res.line_status;
    assign column_count = res.column_count;

endmodule
